// ===== rtl/mmwp_pkg.sv =====
// Shared constants, payload structs and queue entry types for the
// min/max waveform pyramid. No dependencies.
`timescale 1ns / 1ps
package mmwp_pkg;

   localparam int BASE_WINDOW  = 8;
   localparam int LEVELS       = 10;
   localparam int MAX_CHANNELS = 4;

   localparam int SAMPLE_W = 16;
   localparam int CH_W     = 2;
   localparam int LEVEL_W  = 4;
   localparam int CNT_W    = 3;

   localparam int FRAME_W    = (BASE_WINDOW > 1) ? $clog2(BASE_WINDOW) : 1;
   localparam int PAIR_DEPTH = (LEVELS > 1) ? (LEVELS - 1) * MAX_CHANNELS : 1;
   localparam int PAIR_AW    = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
   localparam int PAIR_W     = 2 * SAMPLE_W;

   localparam int JQ_DEPTH = 4;
   localparam int JQ_AW    = $clog2(JQ_DEPTH);
   localparam int OQ_DEPTH = 2;
   localparam int OQ_AW    = $clog2(OQ_DEPTH);

   localparam logic [CNT_W-1:0] CHANNEL_COUNT_RESET = 3'd2;

   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_FLUSH  = 1'b1;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

   typedef struct packed {
      logic                       func;
      logic signed [SAMPLE_W-1:0] sample;
   } req_type;

   typedef struct packed {
      logic [CH_W-1:0]            channel;
      logic [LEVEL_W-1:0]         level;
      logic signed [SAMPLE_W-1:0] min_value;
      logic signed [SAMPLE_W-1:0] max_value;
      logic                       last_of_run;
   } rsp_type;

   // One unit of back-end work: close a window point or flush one channel.
   typedef struct packed {
      logic                       is_flush;
      logic                       has_data;
      logic [CH_W-1:0]            channel;
      logic                       last;
      logic signed [SAMPLE_W-1:0] min_value;
      logic signed [SAMPLE_W-1:0] max_value;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } jq_push_type;

   typedef struct packed {
      logic    empty;
      job_type head;
   } jq_status_type;

endpackage

// ===== rtl/mmwp_front.sv =====
// Front end: takes requests, stages frames, keeps per-channel running min/max
// and queues close/flush jobs. Depends on mmwp_pkg.
`timescale 1ns / 1ps
module mmwp_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [mmwp_pkg::CNT_W-1:0]    csr_wdata,
   input  logic                          req_push,
   output logic                          req_full,
   input  mmwp_pkg::req_type             req_data,
   output mmwp_pkg::jq_push_type         jq_push,
   input  logic                          jq_full
);

   typedef enum logic [1:0] {
      FS_ACCEPT = 2'b01,
      FS_PUSH   = 2'b10
   } front_state_type;

   front_state_type state_ff, state_in;
   logic [mmwp_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [mmwp_pkg::CH_W-1:0]    pos_ff, pos_in;
   logic [mmwp_pkg::FRAME_W-1:0] frame_ff, frame_in;
   logic                         has_ff, has_in;
   logic                         flush_ff, flush_in;
   logic [mmwp_pkg::CH_W-1:0]    push_ch_ff, push_ch_in;
   logic signed [mmwp_pkg::SAMPLE_W-1:0] run_min_ff [mmwp_pkg::MAX_CHANNELS];
   logic signed [mmwp_pkg::SAMPLE_W-1:0] run_min_in [mmwp_pkg::MAX_CHANNELS];
   logic signed [mmwp_pkg::SAMPLE_W-1:0] run_max_ff [mmwp_pkg::MAX_CHANNELS];
   logic signed [mmwp_pkg::SAMPLE_W-1:0] run_max_in [mmwp_pkg::MAX_CHANNELS];
   logic signed [mmwp_pkg::SAMPLE_W-1:0] samp_ff [mmwp_pkg::MAX_CHANNELS];
   logic signed [mmwp_pkg::SAMPLE_W-1:0] samp_in [mmwp_pkg::MAX_CHANNELS];

   logic [mmwp_pkg::CNT_W-1:0] cc;
   logic [mmwp_pkg::CH_W-1:0]  cc_last;
   logic [mmwp_pkg::CH_W-1:0]  pos;
   logic                       accept;
   logic                       push_ok;

   // zero acts as one channel, anything above the maximum as the maximum
   always_comb begin
      if (cnt_ff == '0) begin
         cc = mmwp_pkg::CNT_W'(1);
      end else if (cnt_ff > mmwp_pkg::CNT_W'(mmwp_pkg::MAX_CHANNELS)) begin
         cc = mmwp_pkg::CNT_W'(mmwp_pkg::MAX_CHANNELS);
      end else begin
         cc = cnt_ff;
      end
   end

   assign cc_last  = mmwp_pkg::CH_W'(cc - mmwp_pkg::CNT_W'(1));
   assign pos      = (mmwp_pkg::CNT_W'(pos_ff) >= cc) ? '0 : pos_ff;
   assign req_full = (state_ff != FS_ACCEPT);
   assign accept   = req_push && !req_full;
   assign push_ok  = (state_ff == FS_PUSH) && !jq_full;

   always_comb begin
      jq_push.valid          = push_ok;
      jq_push.job.is_flush   = flush_ff;
      jq_push.job.has_data   = has_ff;
      jq_push.job.channel    = push_ch_ff;
      jq_push.job.last       = (push_ch_ff == cc_last);
      jq_push.job.min_value  = run_min_ff[push_ch_ff];
      jq_push.job.max_value  = run_max_ff[push_ch_ff];
   end

   always_comb begin
      logic signed [mmwp_pkg::SAMPLE_W-1:0] s;
      s          = '0;
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      pos_in     = pos_ff;
      frame_in   = frame_ff;
      has_in     = has_ff;
      flush_in   = flush_ff;
      push_ch_in = push_ch_ff;
      run_min_in = run_min_ff;
      run_max_in = run_max_ff;
      samp_in    = samp_ff;
      if (csr_we) begin
         cnt_in   = csr_wdata;
         state_in = FS_ACCEPT;
         pos_in   = '0;
         frame_in = '0;
         has_in   = 1'b0;
         for (int c = 0; c < mmwp_pkg::MAX_CHANNELS; c++) begin
            run_min_in[c] = mmwp_pkg::SAMPLE_MAX;
            run_max_in[c] = mmwp_pkg::SAMPLE_MIN;
         end
      end else begin
         case (state_ff)
            FS_ACCEPT: begin
               if (accept) begin
                  if (req_data.func == mmwp_pkg::FUNC_FLUSH) begin
                     state_in   = FS_PUSH;
                     flush_in   = 1'b1;
                     push_ch_in = '0;
                  end else if (mmwp_pkg::CNT_W'(pos) + mmwp_pkg::CNT_W'(1) >= cc) begin
                     // frame complete: fold all staged samples into the window
                     pos_in = '0;
                     has_in = 1'b1;
                     for (int c = 0; c < mmwp_pkg::MAX_CHANNELS; c++) begin
                        s = (mmwp_pkg::CH_W'(c) == pos) ? req_data.sample : samp_ff[c];
                        if (mmwp_pkg::CNT_W'(c) < cc) begin
                           if (s < run_min_ff[c]) run_min_in[c] = s;
                           if (s > run_max_ff[c]) run_max_in[c] = s;
                        end
                     end
                     if (frame_ff == mmwp_pkg::FRAME_W'(mmwp_pkg::BASE_WINDOW - 1)) begin
                        frame_in   = '0;
                        state_in   = FS_PUSH;
                        flush_in   = 1'b0;
                        push_ch_in = '0;
                     end else begin
                        frame_in = mmwp_pkg::FRAME_W'(frame_ff + 1'b1);
                     end
                  end else begin
                     samp_in[pos] = req_data.sample;
                     pos_in       = mmwp_pkg::CH_W'(pos + 1'b1);
                  end
               end
            end
            FS_PUSH: begin
               if (!jq_full) begin
                  run_min_in[push_ch_ff] = mmwp_pkg::SAMPLE_MAX;
                  run_max_in[push_ch_ff] = mmwp_pkg::SAMPLE_MIN;
                  if (push_ch_ff == cc_last) begin
                     state_in = FS_ACCEPT;
                     has_in   = 1'b0;
                     if (flush_ff) begin
                        pos_in   = '0;
                        frame_in = '0;
                     end
                  end else begin
                     push_ch_in = mmwp_pkg::CH_W'(push_ch_ff + 1'b1);
                  end
               end
            end
            default: begin
               state_in = FS_ACCEPT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_ACCEPT;
         cnt_ff   <= mmwp_pkg::CHANNEL_COUNT_RESET;
         pos_ff   <= '0;
         frame_ff <= '0;
         has_ff   <= 1'b0;
         flush_ff <= 1'b0;
         for (int c = 0; c < mmwp_pkg::MAX_CHANNELS; c++) begin
            run_min_ff[c] <= mmwp_pkg::SAMPLE_MAX;
            run_max_ff[c] <= mmwp_pkg::SAMPLE_MIN;
         end
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         pos_ff     <= pos_in;
         frame_ff   <= frame_in;
         has_ff     <= has_in;
         flush_ff   <= flush_in;
         run_min_ff <= run_min_in;
         run_max_ff <= run_max_in;
      end
   end

   always_ff @(posedge clock) begin
      push_ch_ff <= push_ch_in;
      samp_ff    <= samp_in;
   end

endmodule

// ===== rtl/mmwp_job_queue.sv =====
// Short job queue between the front end and the pyramid back end.
// Depends on mmwp_pkg.
`timescale 1ns / 1ps
module mmwp_job_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  mmwp_pkg::jq_push_type   jq_push,
   output logic                    jq_full,
   input  logic                    jq_pop,
   output mmwp_pkg::jq_status_type jq_status
);

   mmwp_pkg::job_type           q_ff [mmwp_pkg::JQ_DEPTH];
   logic [mmwp_pkg::JQ_AW-1:0]  wr_ff, wr_in;
   logic [mmwp_pkg::JQ_AW-1:0]  rd_ff, rd_in;
   logic [mmwp_pkg::JQ_AW:0]    cnt_ff, cnt_in;
   logic                        do_push;
   logic                        do_pop;

   assign jq_full          = (cnt_ff == (mmwp_pkg::JQ_AW + 1)'(mmwp_pkg::JQ_DEPTH));
   assign jq_status.empty  = (cnt_ff == '0);
   assign jq_status.head   = q_ff[rd_ff];
   assign do_push          = jq_push.valid && !jq_full;
   assign do_pop           = jq_pop && !jq_status.empty;

   always_comb begin
      wr_in  = do_push ? mmwp_pkg::JQ_AW'(wr_ff + 1'b1) : wr_ff;
      rd_in  = do_pop ? mmwp_pkg::JQ_AW'(rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = (mmwp_pkg::JQ_AW + 1)'(cnt_ff + 1'b1);
      end else if (!do_push && do_pop) begin
         cnt_in = (mmwp_pkg::JQ_AW + 1)'(cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ff] <= jq_push.job;
      end
   end

endmodule

// ===== rtl/mmwp_back.sv =====
// Back end: walks the pyramid levels of one job, one level per cycle unless a full
// result queue stalls it; keeps the pending pair store and result queue. Depends on mmwp_pkg.
`timescale 1ns / 1ps
module mmwp_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    clear,
   input  mmwp_pkg::jq_status_type jq_status,
   output logic                    jq_pop,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output mmwp_pkg::rsp_type       rsp_data
);

   typedef enum logic [1:0] {
      BS_IDLE = 2'b01,
      BS_RUN  = 2'b10
   } back_state_type;

   back_state_type state_ff, state_in;
   logic                          is_flush_ff, is_flush_in;
   logic                          last_ff, last_in;
   logic                          carry_ff, carry_in;
   logic [mmwp_pkg::CH_W-1:0]     ch_ff, ch_in;
   logic [mmwp_pkg::LEVEL_W-1:0]  lvl_ff, lvl_in;
   logic signed [mmwp_pkg::SAMPLE_W-1:0] mn_ff, mn_in, mx_ff, mx_in;
   logic                          valid_ff [mmwp_pkg::PAIR_DEPTH];
   logic                          valid_in [mmwp_pkg::PAIR_DEPTH];

   // pair store: {min, max} per level and channel
   logic [mmwp_pkg::PAIR_W-1:0]   pair_mem [mmwp_pkg::PAIR_DEPTH];
   logic [mmwp_pkg::PAIR_W-1:0]   rd_ff;
   logic                          byp_ff;
   logic [mmwp_pkg::PAIR_W-1:0]   byp_data_ff;
   logic [mmwp_pkg::PAIR_AW-1:0]  rd_addr, cur_addr;
   logic                          we;
   logic [mmwp_pkg::PAIR_W-1:0]   wdata;

   mmwp_pkg::rsp_type             oq_ff [mmwp_pkg::OQ_DEPTH];
   logic [mmwp_pkg::OQ_AW-1:0]    oq_wr_ff, oq_rd_ff;
   logic [mmwp_pkg::OQ_AW:0]      oq_cnt_ff;
   logic                          oq_full;
   logic                          oq_push, oq_pop;
   mmwp_pkg::rsp_type             res;

   logic                          running, top, cur_valid, emit, stall, step;
   logic                          done, start;
   logic [mmwp_pkg::PAIR_W-1:0]   pdata;
   logic signed [mmwp_pkg::SAMPLE_W-1:0] pmn, pmx, m_mn, m_mx;

   function automatic logic [mmwp_pkg::PAIR_AW-1:0] pair_addr(
      input logic [mmwp_pkg::LEVEL_W-1:0] level,
      input logic [mmwp_pkg::CH_W-1:0]    ch
   );
      logic [mmwp_pkg::PAIR_AW-1:0] a;
      if (32'(level) >= mmwp_pkg::LEVELS - 1) begin
         a = '0;
      end else begin
         a = mmwp_pkg::PAIR_AW'(32'(level) * mmwp_pkg::MAX_CHANNELS + 32'(ch));
      end
      return a;
   endfunction

   assign running   = (state_ff == BS_RUN);
   assign top       = (lvl_ff == mmwp_pkg::LEVEL_W'(mmwp_pkg::LEVELS - 1));
   assign cur_addr  = pair_addr(lvl_ff, ch_ff);
   assign cur_valid = !top && valid_ff[cur_addr];
   assign pdata     = byp_ff ? byp_data_ff : rd_ff;
   assign pmn       = pdata[mmwp_pkg::PAIR_W-1:mmwp_pkg::SAMPLE_W];
   assign pmx       = pdata[mmwp_pkg::SAMPLE_W-1:0];

   // with no carried point a pending pair passes through unchanged
   assign m_mn = (carry_ff && (mn_ff < pmn)) ? mn_ff : pmn;
   assign m_mx = (carry_ff && (mx_ff > pmx)) ? mx_ff : pmx;

   assign oq_full = (oq_cnt_ff == (mmwp_pkg::OQ_AW + 1)'(mmwp_pkg::OQ_DEPTH));
   assign emit    = running && carry_ff;
   assign stall   = emit && oq_full;
   assign step    = running && !stall;
   assign done    = is_flush_ff ? top : (top || !cur_valid);
   assign start   = !jq_status.empty && ((state_ff == BS_IDLE) || (step && done)) && !clear;
   assign jq_pop  = start;
   assign oq_push = emit && !stall;
   assign we      = step && !is_flush_ff && !top && !cur_valid;
   assign wdata   = {mn_ff, mx_ff};

   always_comb begin
      res.channel     = ch_ff;
      res.level       = lvl_ff;
      res.min_value   = mn_ff;
      res.max_value   = mx_ff;
      res.last_of_run = last_ff && done;
   end

   always_comb begin
      if (start) begin
         rd_addr = pair_addr('0, jq_status.head.channel);
      end else if (step && !done) begin
         rd_addr = pair_addr(mmwp_pkg::LEVEL_W'(lvl_ff + 1'b1), ch_ff);
      end else begin
         rd_addr = cur_addr;
      end
   end

   always_comb begin
      state_in    = state_ff;
      is_flush_in = is_flush_ff;
      last_in     = last_ff;
      carry_in    = carry_ff;
      ch_in       = ch_ff;
      lvl_in      = lvl_ff;
      mn_in       = mn_ff;
      mx_in       = mx_ff;
      valid_in    = valid_ff;
      if (clear) begin
         state_in = BS_IDLE;
         for (int i = 0; i < mmwp_pkg::PAIR_DEPTH; i++) valid_in[i] = 1'b0;
      end else begin
         if (step && !top) begin
            if (cur_valid) begin
               valid_in[cur_addr] = 1'b0;
            end else if (!is_flush_ff) begin
               valid_in[cur_addr] = 1'b1;
            end
         end
         if (start) begin
            state_in    = BS_RUN;
            is_flush_in = jq_status.head.is_flush;
            last_in     = jq_status.head.last;
            carry_in    = !jq_status.head.is_flush || jq_status.head.has_data;
            ch_in       = jq_status.head.channel;
            lvl_in      = '0;
            mn_in       = jq_status.head.min_value;
            mx_in       = jq_status.head.max_value;
         end else if (step && done) begin
            state_in = BS_IDLE;
         end else if (step) begin
            lvl_in   = mmwp_pkg::LEVEL_W'(lvl_ff + 1'b1);
            carry_in = carry_ff || cur_valid;
            if (cur_valid) begin
               mn_in = m_mn;
               mx_in = m_mx;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BS_IDLE;
         for (int i = 0; i < mmwp_pkg::PAIR_DEPTH; i++) valid_ff[i] <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      is_flush_ff <= is_flush_in;
      last_ff     <= last_in;
      carry_ff    <= carry_in;
      ch_ff       <= ch_in;
      lvl_ff      <= lvl_in;
      mn_ff       <= mn_in;
      mx_ff       <= mx_in;
   end

   // registered read; a write to the slot being read is forwarded
   always_ff @(posedge clock) begin
      if (we) begin
         pair_mem[cur_addr] <= wdata;
      end
      rd_ff       <= pair_mem[rd_addr];
      byp_data_ff <= wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else begin
         byp_ff <= we && (cur_addr == rd_addr);
      end
   end

   // result queue
   assign rsp_empty = (oq_cnt_ff == '0);
   assign rsp_data  = oq_ff[oq_rd_ff];
   assign oq_pop    = rsp_pop && !rsp_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wr_ff  <= '0;
         oq_rd_ff  <= '0;
         oq_cnt_ff <= '0;
      end else begin
         if (oq_push) oq_wr_ff <= mmwp_pkg::OQ_AW'(oq_wr_ff + 1'b1);
         if (oq_pop) oq_rd_ff <= mmwp_pkg::OQ_AW'(oq_rd_ff + 1'b1);
         if (oq_push && !oq_pop) begin
            oq_cnt_ff <= (mmwp_pkg::OQ_AW + 1)'(oq_cnt_ff + 1'b1);
         end else if (!oq_push && oq_pop) begin
            oq_cnt_ff <= (mmwp_pkg::OQ_AW + 1)'(oq_cnt_ff - 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (oq_push) begin
         oq_ff[oq_wr_ff] <= res;
      end
   end

endmodule

// ===== rtl/minmax_waveform_pyramid_unit.sv =====
// Top level of the min/max waveform pyramid: front end, job queue, back end.
// Depends on mmwp_pkg, mmwp_front, mmwp_job_queue, mmwp_back.
//
//   channel   ports                          direction  handshake
//   request   req_push, req_full, req_data   in         push & !full
//   response  rsp_pop, rsp_empty, rsp_data   out        pop & !empty
//   csr       csr_we, csr_wdata              in         we, no wait
//
// A sample request is taken every cycle except when a window closes or a flush
// arrives: the front end then queues one job per active channel before it takes
// more. The back end walks one pyramid level per cycle; a close job stops at the
// first empty pair slot or the top level, a flush job at the top level. Results
// wait in a 2-entry queue; a full queue stalls the back end, a full job queue
// stalls the front end. Reset is synchronous; no clearing pass.
`timescale 1ns / 1ps
module minmax_waveform_pyramid_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  mmwp_pkg::req_type           req_data,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output mmwp_pkg::rsp_type           rsp_data,
   input  logic                        csr_we,
   input  logic [mmwp_pkg::CNT_W-1:0]  csr_wdata
);

   mmwp_pkg::jq_push_type   jq_push;
   mmwp_pkg::jq_status_type jq_status;
   logic                    jq_full;
   logic                    jq_pop;

   mmwp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .jq_push   (jq_push),
      .jq_full   (jq_full)
   );

   mmwp_job_queue u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .jq_push   (jq_push),
      .jq_full   (jq_full),
      .jq_pop    (jq_pop),
      .jq_status (jq_status)
   );

   mmwp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .clear     (csr_we),
      .jq_status (jq_status),
      .jq_pop    (jq_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
